// File: rtl/array_list_table_engine_unit_defines.svh
// Assertion macros used by the list engine RTL.
`ifndef ARRAY_LIST_TABLE_ENGINE_UNIT_DEFINES_SVH
`define ARRAY_LIST_TABLE_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define ALTE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ALTE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/alte_pkg.sv
// Shared constants and codes of the list engine.
`default_nettype none

package alte_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int WORD_W   = 32;
    localparam int IDX_W    = 8;
    localparam int CMD_W    = 3;
    localparam int STAT_W   = 2;

    localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_EDIT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_MISSING = 2'd3;

endpackage

`default_nettype wire

// File: rtl/array_list_table_engine_unit.sv
// Top level of the list engine: command sequencer, entry RAM and result register.
`default_nettype none

`include "array_list_table_engine_unit_defines.svh"

// A fixed-capacity list of signed 32-bit words held in one RAM. Each input item
// carries a command (append, get, edit, search, remove first match) and returns
// exactly one result item with a status, a data word, a one-based match position
// and the entry count after the command. The block works on one item at a time:
// s_tready is high only while the sequencer is idle. An append writes its entry
// in the execute step, get and edit read one entry, and search and remove walk
// the list; the walk and the shift-down move one entry per cycle through the
// RAM's single read port and single write port. s_tready returns in the cycle
// after the load. A finished result sits in an output register, so a new item
// may be accepted while it waits; the sequencer stalls at its last step only if
// the previous result is still unread. Reset clears the entry count at once;
// words at or past the count are never read, so the RAM needs no clearing pass.
module array_list_table_engine_unit
    import alte_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [7:0] index, [39:8] value
    input  wire logic [2:0]  s_tuser,   // [2:0] cmd
    // Result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [55:0] m_tdata,   // [31:0] data, [40:32] position,
                                        // [49:41] count, [55:50] zero
    output logic      [1:0]  m_tuser    // [1:0] status
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_SHIFT = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  ptr_inc;
    logic [CMD_W-1:0]  cmd_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [WORD_W-1:0] val_reg;

    // Result under construction
    logic [STAT_W-1:0] res_stat_reg, res_stat_next;
    logic [WORD_W-1:0] res_data_reg, res_data_next;
    logic [CNT_W-1:0]  res_pos_reg, res_pos_next;

    // Output register
    logic              m_valid_reg;
    logic [55:0]       m_data_reg;
    logic [1:0]        m_user_reg;

    // RAM port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;

    logic s_fire, out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign ptr_inc  = ptr_reg + CNT_W'(1);

    alte_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        res_stat_next = res_stat_reg;
        res_data_next = res_data_reg;
        res_pos_next  = res_pos_reg;
        ram_we        = 1'b0;
        ram_waddr     = ptr_reg[ADDR_W-1:0];
        ram_wdata     = val_reg;
        ram_raddr     = ptr_reg[ADDR_W-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    ptr_next      = '0;
                    res_stat_next = STAT_OK;
                    res_data_next = '0;
                    res_pos_next  = '0;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (cmd_reg)
                    CMD_APPEND: begin
                        if (count_reg >= CAP_COUNT) begin
                            res_stat_next = STAT_FULL;
                        end else begin
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[ADDR_W-1:0];
                            count_next = count_reg + CNT_W'(1);
                        end
                        state_next = ST_DONE;
                    end
                    CMD_GET, CMD_EDIT: begin
                        if (CNT_W'(idx_reg) < count_reg) begin
                            ram_raddr  = ADDR_W'(idx_reg);
                            state_next = ST_READ;
                        end else begin
                            res_stat_next = STAT_RANGE;
                            state_next    = ST_DONE;
                        end
                    end
                    CMD_SEARCH, CMD_REMOVE: begin
                        if (count_reg == '0) begin
                            res_stat_next = STAT_MISSING;
                            state_next    = ST_DONE;
                        end else begin
                            // prime the walk with entry 0
                            ram_raddr  = '0;
                            state_next = ST_SCAN;
                        end
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_READ: begin
                res_data_next = ram_rdata;
                if (cmd_reg == CMD_EDIT) begin
                    ram_we    = 1'b1;
                    ram_waddr = ADDR_W'(idx_reg);
                end
                state_next = ST_DONE;
            end
            ST_SCAN: begin
                // ram_rdata holds the entry at ptr_reg
                if (ram_rdata == val_reg) begin
                    res_pos_next = ptr_inc;
                    if (cmd_reg == CMD_SEARCH) begin
                        state_next = ST_DONE;
                    end else if (ptr_inc >= count_reg) begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = ST_DONE;
                    end else begin
                        ram_raddr  = ptr_inc[ADDR_W-1:0];
                        ptr_next   = ptr_inc;
                        state_next = ST_SHIFT;
                    end
                end else if (ptr_inc >= count_reg) begin
                    res_stat_next = STAT_MISSING;
                    state_next    = ST_DONE;
                end else begin
                    ram_raddr = ptr_inc[ADDR_W-1:0];
                    ptr_next  = ptr_inc;
                end
            end
            ST_SHIFT: begin
                // move the entry at ptr_reg down one place
                ram_we    = 1'b1;
                ram_waddr = ptr_reg[ADDR_W-1:0] - ADDR_W'(1);
                ram_wdata = ram_rdata;
                if (ptr_inc >= count_reg) begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_DONE;
                end else begin
                    ram_raddr = ptr_inc[ADDR_W-1:0];
                    ptr_next  = ptr_inc;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset
    always_ff @(posedge aclk) begin
        ptr_reg      <= ptr_next;
        res_stat_reg <= res_stat_next;
        res_data_reg <= res_data_next;
        res_pos_reg  <= res_pos_next;
        if (s_fire) begin
            cmd_reg <= s_tuser;
            idx_reg <= s_tdata[7:0];
            val_reg <= s_tdata[39:8];
        end
        if (state_reg == ST_DONE && out_free) begin
            m_data_reg <= {6'd0, count_reg, res_pos_reg, res_data_reg};
            m_user_reg <= res_stat_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    `ALTE_ASSERT_NOW(a_count_cap, aclk, aresetn, 1'b1, count_reg <= CAP_COUNT,
        "entry count above capacity")
    `ALTE_ASSERT_NEXT(a_accept_exec, aclk, aresetn, s_fire, state_reg == ST_EXEC,
        "accepted item did not start execution")
    `ALTE_ASSERT_NOW(a_walk_bound, aclk, aresetn,
        (state_reg == ST_SCAN) || (state_reg == ST_SHIFT), ptr_reg < count_reg,
        "walk pointer past entry count")
    `ALTE_ASSERT_NEXT(a_count_step, aclk, aresetn, 1'b1,
        (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + CNT_W'(1))
            || (count_reg == $past(count_reg) - CNT_W'(1)),
        "entry count moved by more than one")

endmodule

`default_nettype wire

// File: rtl/alte_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module alte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
